// ===== design/ocp_pkg.sv =====
// Shared types and constants of the order crossover permutation unit.
`default_nettype none

package ocp_pkg;

  // Fixed widths of the configuration register and of the port fields.
  localparam int unsigned CFG_W = 7;
  localparam int unsigned CUT_W = 6;
  localparam int unsigned POS_W = 6;

  // Permutation length after reset.
  localparam logic [CFG_W-1:0] PERM_LENGTH_RESET = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // store one parent gene pair
    logic build_init;    // set up cuts, pointers and clear valid bits
    logic copy_wr;       // write one first-parent slice gene into the child
    logic cnt_inc;       // advance the slice or output counter
    logic gene_capture;  // latch a second-parent gene and restart the slice scan
    logic fill_wr;       // place the latched gene at the fill position
    logic gene_adv;      // step to the next second-parent gene
    logic out_init;      // rewind the counter for the child run
    logic out_rd;        // read one child position for output
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_item;    // the item being loaded is the last position
    logic at_hi;         // counter sits on the high cut
    logic scan_match;    // scanned slice entry equals the latched gene
    logic gene_last;     // last second-parent gene is being handled
    logic out_last;      // counter sits on the last child position
  } status_t;

endpackage

`default_nettype wire

// ===== design/ocp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ocp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/ocp_datapath.sv =====
// Datapath of the order crossover unit: parent and child stores, pointers, output stage.
`default_nettype none

module ocp_datapath #(
  parameter int unsigned MAX_GENES  = 64,
  parameter int unsigned GENE_WIDTH = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ocp_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic [GENE_WIDTH-1:0]      gene_first_parent_i,
  input  wire logic [GENE_WIDTH-1:0]      gene_second_parent_i,
  input  wire logic [ocp_pkg::CUT_W-1:0]  cut_a_i,
  input  wire logic [ocp_pkg::CUT_W-1:0]  cut_b_i,
  input  wire ocp_pkg::cmd_t              cmd_i,
  output ocp_pkg::status_t                status_o,
  output logic                            child_valid_o,
  output logic      [GENE_WIDTH-1:0]      child_gene_o,
  output logic      [ocp_pkg::POS_W-1:0]  child_position_o,
  output logic                            last_gene_o
);

  import ocp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_GENES);
  localparam int unsigned LEN_W = $clog2(MAX_GENES + 1);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v,
                                                input logic [IDX_W-1:0] lim);
    logic [IDX_W-1:0] r;
    r = (v == lim) ? '0 : IDX_W'(v + 1'b1);
    return r;
  endfunction

  logic [CFG_W-1:0]     perm_length_q, perm_length_d;
  logic [IDX_W-1:0]     load_pos_q, load_pos_d;
  logic [MAX_GENES-1:0] valid_q, valid_d;
  logic                 out_pend_q, out_pend_d;

  logic [IDX_W-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d, src_q, src_d, pos_q, pos_d, k_q, k_d;
  logic [GENE_WIDTH-1:0] g_q, g_d;
  logic [IDX_W-1:0]     out_pos_q, out_pos_d;
  logic                 out_last_q, out_last_d, out_vld_q, out_vld_d;

  logic [LEN_W-1:0]     len_act, len_m1;
  logic [IDX_W-1:0]     last_idx;
  logic [CUT_W-1:0]     lo_raw, hi_raw;
  logic [IDX_W-1:0]     lo_cl, hi_cl;
  logic                 final_item;

  logic [GENE_WIDTH-1:0] fp_rd, sp_rd, child_rd;
  logic                  child_we;
  logic [IDX_W-1:0]      child_waddr;
  logic [GENE_WIDTH-1:0] child_wdata;

  // Length in use: zero acts as one, values above the capacity saturate.
  always_comb begin
    if (perm_length_q == '0) begin
      len_act = LEN_W'(1);
    end else if (perm_length_q > CFG_W'(MAX_GENES)) begin
      len_act = LEN_W'(MAX_GENES);
    end else begin
      len_act = perm_length_q[LEN_W-1:0];
    end
    len_m1   = len_act - LEN_W'(1);
    last_idx = len_m1[IDX_W-1:0];
  end

  assign final_item = (LEN_W'(load_pos_q) + LEN_W'(1)) >= len_act;

  // Order the cuts, then clamp each to the last position.
  always_comb begin
    lo_raw = (cut_a_i < cut_b_i) ? cut_a_i : cut_b_i;
    hi_raw = (cut_a_i < cut_b_i) ? cut_b_i : cut_a_i;
    lo_cl  = (lo_raw > CUT_W'(last_idx)) ? last_idx : lo_raw[IDX_W-1:0];
    hi_cl  = (hi_raw > CUT_W'(last_idx)) ? last_idx : hi_raw[IDX_W-1:0];
  end

  ocp_ram #(.WIDTH(GENE_WIDTH), .DEPTH(MAX_GENES)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (load_pos_q),
    .wdata_i (gene_first_parent_i),
    .raddr_i (cnt_q),
    .rdata_o (fp_rd)
  );

  ocp_ram #(.WIDTH(GENE_WIDTH), .DEPTH(MAX_GENES)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (load_pos_q),
    .wdata_i (gene_second_parent_i),
    .raddr_i (src_q),
    .rdata_o (sp_rd)
  );

  assign child_we    = cmd_i.copy_wr | cmd_i.fill_wr;
  assign child_waddr = cmd_i.fill_wr ? pos_q : cnt_q;
  assign child_wdata = cmd_i.fill_wr ? g_q : fp_rd;

  ocp_ram #(.WIDTH(GENE_WIDTH), .DEPTH(MAX_GENES)) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (child_wdata),
    .raddr_i (cnt_q),
    .rdata_o (child_rd)
  );

  always_comb begin
    perm_length_d = perm_length_q;
    load_pos_d    = load_pos_q;
    valid_d       = valid_q;
    out_pend_d    = 1'b0;
    lo_d          = lo_q;
    hi_d          = hi_q;
    cnt_d         = cnt_q;
    src_d         = src_q;
    pos_d         = pos_q;
    k_d           = k_q;
    g_d           = g_q;
    out_pos_d     = out_pos_q;
    out_last_d    = out_last_q;
    out_vld_d     = out_vld_q;

    if (cfg_we_i) begin
      perm_length_d = cfg_data_i;
    end
    if (cmd_i.load) begin
      load_pos_d = final_item ? '0 : IDX_W'(load_pos_q + 1'b1);
    end
    if (cmd_i.build_init) begin
      valid_d = '0;
      lo_d    = lo_cl;
      hi_d    = hi_cl;
      cnt_d   = lo_cl;
      src_d   = wrap_inc(hi_cl, last_idx);
      pos_d   = wrap_inc(hi_cl, last_idx);
      k_d     = '0;
    end
    if (cmd_i.copy_wr) begin
      valid_d[cnt_q] = 1'b1;
    end
    if (cmd_i.cnt_inc) begin
      cnt_d = IDX_W'(cnt_q + 1'b1);
    end
    if (cmd_i.gene_capture) begin
      g_d   = sp_rd;
      cnt_d = lo_q;
    end
    if (cmd_i.fill_wr) begin
      valid_d[pos_q] = 1'b1;
      pos_d          = wrap_inc(pos_q, last_idx);
    end
    if (cmd_i.gene_adv) begin
      k_d   = IDX_W'(k_q + 1'b1);
      src_d = wrap_inc(src_q, last_idx);
    end
    if (cmd_i.out_init) begin
      cnt_d = '0;
    end
    if (cmd_i.out_rd) begin
      out_pend_d = 1'b1;
      out_pos_d  = cnt_q;
      out_last_d = (cnt_q == last_idx);
      out_vld_d  = valid_q[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_length_q <= PERM_LENGTH_RESET;
      load_pos_q    <= '0;
      valid_q       <= '0;
      out_pend_q    <= 1'b0;
    end else begin
      perm_length_q <= perm_length_d;
      load_pos_q    <= load_pos_d;
      valid_q       <= valid_d;
      out_pend_q    <= out_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    cnt_q      <= cnt_d;
    src_q      <= src_d;
    pos_q      <= pos_d;
    k_q        <= k_d;
    g_q        <= g_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
    out_vld_q  <= out_vld_d;
  end

  assign status_o.final_item = final_item;
  assign status_o.at_hi      = (cnt_q == hi_q);
  assign status_o.scan_match = (child_rd == g_q);
  assign status_o.gene_last  = (k_q == last_idx);
  assign status_o.out_last   = (cnt_q == last_idx);

  assign child_valid_o    = out_pend_q;
  assign child_gene_o     = out_vld_q ? child_rd : '0;
  assign child_position_o = POS_W'(out_pos_q);
  assign last_gene_o      = out_last_q;

endmodule

`default_nettype wire

// ===== design/ocp_controller.sv =====
// Controller state machine that sequences loading, slice copy, fill and output.
`default_nettype none

module ocp_controller (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire ocp_pkg::status_t status_i,
  output ocp_pkg::cmd_t         cmd_o,
  output logic                  busy_o
);

  import ocp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_COPY_RD  = 10'b00_0000_0010,
    S_COPY_WR  = 10'b00_0000_0100,
    S_FILL_RD  = 10'b00_0000_1000,
    S_FILL_G   = 10'b00_0001_0000,
    S_SCAN_RD  = 10'b00_0010_0000,
    S_SCAN_CMP = 10'b00_0100_0000,
    S_WRITE    = 10'b00_1000_0000,
    S_ADV      = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (status_i.final_item) begin
            cmd_o.build_init = 1'b1;
            state_d          = S_COPY_RD;
          end
        end
      end
      S_COPY_RD: begin
        state_d = S_COPY_WR;
      end
      S_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        if (status_i.at_hi) begin
          state_d = S_FILL_RD;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_COPY_RD;
        end
      end
      S_FILL_RD: begin
        state_d = S_FILL_G;
      end
      S_FILL_G: begin
        cmd_o.gene_capture = 1'b1;
        state_d            = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (status_i.scan_match) begin
          state_d = S_ADV;
        end else if (status_i.at_hi) begin
          state_d = S_WRITE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_WRITE: begin
        cmd_o.fill_wr = 1'b1;
        state_d       = S_ADV;
      end
      S_ADV: begin
        if (status_i.gene_last) begin
          cmd_o.out_init = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.gene_adv = 1'b1;
          state_d        = S_FILL_RD;
        end
      end
      S_OUT: begin
        cmd_o.out_rd  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.out_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== design/order_crossover_permutation_unit.sv =====
// Top level of the order crossover (OX) permutation unit.
`default_nettype none

// The unit builds one child permutation from two parents by order crossover.
// Each start transaction loads one position of both parents, and busy
// stays low between loads. The transaction for the final position
// (perm_length - 1) also carries the two cut points and starts the build,
// during which busy is high. The build copies the first parent's slice,
// reading and then writing each slice gene, then walks the second parent
// once around starting after the slice. Each second-parent gene is read
// and latched, then compared with the slice entries, written to the next
// fill position if no entry matched, and then the walk advances; the
// comparison reads the child store through its single read port, reading
// and then comparing one slice entry at a time, and stops at the first
// match. The child then leaves as perm_length result transactions, one per
// cycle, the last one flagged by last_gene_o, with the final result
// appearing in the first cycle in which busy is low again. Results are
// shown for exactly one cycle under child_valid_o and cannot be held off,
// so the receiver must take every result when it appears. The length
// register accepts writes at any time but must only be changed while the
// unit is idle; 0 behaves as 1 and values above MAX_GENES behave as
// MAX_GENES. A child position that receives no gene, which only happens when
// the parents are not permutations of the same set, is reported as 0.

module order_crossover_permutation_unit #(
  parameter int unsigned MAX_GENES  = 64,
  parameter int unsigned GENE_WIDTH = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Item channel.
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [GENE_WIDTH-1:0]     gene_first_parent_i,
  input  wire logic [GENE_WIDTH-1:0]     gene_second_parent_i,
  input  wire logic [ocp_pkg::CUT_W-1:0] cut_a_i,
  input  wire logic [ocp_pkg::CUT_W-1:0] cut_b_i,
  // Length register write channel.
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [ocp_pkg::CFG_W-1:0] cfg_perm_length_i,
  // Result channel.
  output logic                           child_valid_o,
  output logic      [GENE_WIDTH-1:0]     child_gene_o,
  output logic      [ocp_pkg::POS_W-1:0] child_position_o,
  output logic                           last_gene_o
);

  import ocp_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    start_acc;

  // The length register can always take a write.
  assign cfg_ready_o = 1'b1;

  // An item is taken only while the controller is not building a child.
  assign start_acc = start & ~busy;

  ocp_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_acc),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  ocp_datapath #(
    .MAX_GENES  (MAX_GENES),
    .GENE_WIDTH (GENE_WIDTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_valid_i & cfg_ready_o),
    .cfg_data_i           (cfg_perm_length_i),
    .gene_first_parent_i  (gene_first_parent_i),
    .gene_second_parent_i (gene_second_parent_i),
    .cut_a_i              (cut_a_i),
    .cut_b_i              (cut_b_i),
    .cmd_i                (cmd),
    .status_o             (status),
    .child_valid_o        (child_valid_o),
    .child_gene_o         (child_gene_o),
    .child_position_o     (child_position_o),
    .last_gene_o          (last_gene_o)
  );

endmodule

`default_nettype wire
